// ----- rtl/sscnt_pkg.sv -----
package sscnt_pkg;

  localparam int MAX_PATTERN = 128;
  localparam int COUNT_WIDTH = 64;
  localparam int LEN_W = $clog2(MAX_PATTERN + 1);

  typedef enum logic {
    CMD_PATTERN = 1'b0,
    CMD_TEXT    = 1'b1
  } cmd_t;

  typedef struct packed {
    logic       cmd;
    logic       first;
    logic [7:0] symbol;
  } in_beat_t;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] count;
    logic                   overflow;
    logic                   pattern_full;
  } out_beat_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic step;
    logic active;
    logic is_last;
  } cell_ctrl_t;

endpackage

// ----- rtl/sscnt_cell.sv -----
module sscnt_cell (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  sscnt_pkg::cell_ctrl_t                    ctrl,
  input  logic [7:0]                               symbol,
  input  logic [sscnt_pkg::COUNT_WIDTH-1:0]        next_count,
  output logic [sscnt_pkg::COUNT_WIDTH-1:0]        count_r,
  output logic [sscnt_pkg::COUNT_WIDTH-1:0]        count_nxt,
  output logic                                     ovf
);

  localparam int CW = sscnt_pkg::COUNT_WIDTH;

  logic [7:0]    sym_r;
  logic [CW-1:0] addend;
  logic [CW:0]   sum;
  logic          hit;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      sym_r <= symbol;
    end
  end

  always_comb begin
    addend    = ctrl.is_last ? CW'(1) : next_count;
    sum       = {1'b0, count_r} + {1'b0, addend};
    hit       = ctrl.step && ctrl.active && (sym_r == symbol);
    ovf       = hit && sum[CW];
    count_nxt = count_r;
    if (ctrl.clear || ctrl.load) begin
      count_nxt = '0;
    end else if (hit) begin
      count_nxt = sum[CW] ? {CW{1'b1}} : sum[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

// ----- rtl/subsequence_occurrence_counter_core.sv -----
// Counts the ways a pattern of up to 128 bytes occurs as a subsequence of a text. Load the
// pattern with command 0 beats (first set on the opening byte clears pattern, counts and the
// overflow flag), then send the text with command 1 beats, last byte first. Every beat
// returns one result: the saturating 64-bit count for the whole pattern, a sticky overflow
// flag and a flag that marks a pattern byte dropped because the store was full. A row of
// 128 cells, one per pattern position, updates in parallel in the cycle a beat is accepted,
// and the beat's result is registered for the next cycle; a new beat is taken every cycle
// as long as the result side does not stall. No clearing pass follows reset.
module subsequence_occurrence_counter_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sscnt_pkg::in_beat_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sscnt_pkg::out_beat_t out_data
);

  localparam int NP    = sscnt_pkg::MAX_PATTERN;
  localparam int CW    = sscnt_pkg::COUNT_WIDTH;
  localparam int LEN_W = sscnt_pkg::LEN_W;

  logic [LEN_W-1:0]     len_r, len_nxt, base_len;
  logic                 ovf_seen_r, ovf_seen_nxt;
  logic                 out_valid_r, out_valid_nxt;
  sscnt_pkg::out_beat_t out_r, out_nxt;
  logic                 accept, append, text, clear, full;
  logic [CW-1:0]        counts [NP+1];
  logic [CW-1:0]        counts_nxt [NP];
  logic [NP-1:0]        ovf_vec;

  assign accept = in_valid && !in_stall;
  assign append = accept && (in_data.cmd == sscnt_pkg::CMD_PATTERN);
  assign text   = accept && (in_data.cmd == sscnt_pkg::CMD_TEXT);
  assign clear  = append && in_data.first;
  assign base_len = clear ? '0 : len_r;
  assign full   = (base_len == LEN_W'(NP));
  assign counts[NP] = '0;

  for (genvar i = 0; i < NP; i++) begin : g_cell
    sscnt_pkg::cell_ctrl_t ctrl;
    always_comb begin
      ctrl.clear   = clear;
      ctrl.load    = append && !full && (base_len == LEN_W'(i));
      ctrl.step    = text;
      ctrl.active  = (LEN_W'(i) < len_r);
      ctrl.is_last = (LEN_W'(i + 1) == len_r);
    end
    sscnt_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .symbol     (in_data.symbol),
      .next_count (counts[i+1]),
      .count_r    (counts[i]),
      .count_nxt  (counts_nxt[i]),
      .ovf        (ovf_vec[i])
    );
  end

  always_comb begin
    len_nxt       = len_r;
    ovf_seen_nxt  = ovf_seen_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (append) begin
      len_nxt      = full ? base_len : base_len + LEN_W'(1);
      ovf_seen_nxt = ovf_seen_r && !clear;
    end else if (text) begin
      ovf_seen_nxt = ovf_seen_r || (|ovf_vec);
    end
    if (accept) begin
      out_valid_nxt        = 1'b1;
      out_nxt.count        = (len_nxt != '0) ? counts_nxt[0] : '0;
      out_nxt.overflow     = ovf_seen_nxt;
      out_nxt.pattern_full = append && full;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      ovf_seen_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      ovf_seen_r  <= ovf_seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign in_stall  = out_valid_r && out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(NP))
    else $error("pattern length beyond store depth");

  a_first_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    clear |=> (len_r == LEN_W'(1)) && !ovf_seen_r)
    else $error("first pattern beat did not restart the pattern");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    append && !in_data.first && (len_r == LEN_W'(NP)) |=>
      out_r.pattern_full && (len_r == LEN_W'(NP)))
    else $error("full store did not drop the pattern byte");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.count != '0) |-> (len_r != '0))
    else $error("nonzero count with an empty pattern");

endmodule
